// File: rtl/assert_macros.svh
// assertion macros used by the alu rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising edge outside reset
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent at one edge implies consequent at the next edge
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/m6502alu_pkg.sv
// operation codes and helpers for the 6502 adc and undocumented-op alu
package m6502alu_pkg;

  localparam int unsigned KIND_W = 4;
  localparam int unsigned DATA_W = 8;

  typedef enum logic [KIND_W-1:0] {
    KIND_ADC = 4'd0,
    KIND_ALR = 4'd1,
    KIND_ANC = 4'd2,
    KIND_ARR = 4'd3,
    KIND_AXS = 4'd4,
    KIND_DCP = 4'd5,
    KIND_ISB = 4'd6,
    KIND_LAX = 4'd7,
    KIND_RLA = 4'd8,
    KIND_RRA = 4'd9,
    KIND_SAX = 4'd10,
    KIND_SHX = 4'd11,
    KIND_SHY = 4'd12,
    KIND_SLO = 4'd13,
    KIND_SRE = 4'd14
  } kind_t;

  typedef struct packed {
    logic [DATA_W-1:0] res;
    logic              c;
    logic              v;
  } add_res_t;

  // binary add with carry, 6502 carry and overflow rules
  function automatic add_res_t adc_f(input logic [DATA_W-1:0] a,
                                     input logic [DATA_W-1:0] m,
                                     input logic              cin);
    logic [DATA_W:0] sum;
    add_res_t        r;
    sum   = {1'b0, a} + {1'b0, m} + {{DATA_W{1'b0}}, cin};
    r.res = sum[DATA_W-1:0];
    r.c   = sum[DATA_W];
    r.v   = (m[DATA_W-1] ^ r.res[DATA_W-1]) & (r.res[DATA_W-1] ^ a[DATA_W-1]);
    return r;
  endfunction

endpackage

// File: rtl/mos6502_adc_and_illegal_op_alu.sv
// 6502 alu slice: adc and the undocumented alr..sre operations, two-stage pipeline
// path: an accepted item passes the input register, then the result register, before out_valid rises
// throughput: one item per cycle while out_stall is low; the combinational alu sits between
//   the input register and the result register
// stall passes back through both stages, so a full pipeline holds two items
// reset: synchronous active-low rst_n clears both stage valid bits; payload not reset
`include "assert_macros.svh"

module mos6502_adc_and_illegal_op_alu import m6502alu_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  // input channel
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [KIND_W-1:0] in_kind,
  input  logic [DATA_W-1:0] in_acc_in,
  input  logic [DATA_W-1:0] in_xreg_in,
  input  logic [DATA_W-1:0] in_yreg_in,
  input  logic [DATA_W-1:0] in_mem_byte,
  input  logic [DATA_W-1:0] in_base_high,
  input  logic              in_carry_in,
  input  logic              in_zero_in,
  input  logic              in_negative_in,
  input  logic              in_overflow_in,
  // result channel
  output logic              out_valid,
  input  logic              out_stall,
  output logic [DATA_W-1:0] out_acc_out,
  output logic [DATA_W-1:0] out_xreg_out,
  output logic [DATA_W-1:0] out_write_byte,
  output logic              out_write_enable,
  output logic              out_carry_out,
  output logic              out_zero_out,
  output logic              out_negative_out,
  output logic              out_overflow_out
);

  // input register
  logic              s1_valid_r;
  logic              s1_valid_nxt;
  logic [KIND_W-1:0] s1_kind_r;
  logic [DATA_W-1:0] s1_acc_r;
  logic [DATA_W-1:0] s1_xreg_r;
  logic [DATA_W-1:0] s1_yreg_r;
  logic [DATA_W-1:0] s1_mem_r;
  logic [DATA_W-1:0] s1_base_high_r;
  logic              s1_c_r;
  logic              s1_z_r;
  logic              s1_n_r;
  logic              s1_v_r;

  // stage control: the result stage moves when empty or taken,
  // the input stage moves when empty or the result stage moves
  logic adv_out;
  logic adv_in;

  assign adv_out  = !out_valid || !out_stall;
  assign adv_in   = !s1_valid_r || adv_out;
  assign in_stall = !adv_in;

  assign s1_valid_nxt = adv_in ? in_valid : s1_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_in && in_valid) begin
      s1_kind_r      <= in_kind;
      s1_acc_r       <= in_acc_in;
      s1_xreg_r      <= in_xreg_in;
      s1_yreg_r      <= in_yreg_in;
      s1_mem_r       <= in_mem_byte;
      s1_base_high_r <= in_base_high;
      s1_c_r         <= in_carry_in;
      s1_z_r         <= in_zero_in;
      s1_n_r         <= in_negative_in;
      s1_v_r         <= in_overflow_in;
    end
  end

  // alu
  logic [DATA_W-1:0] a_nxt;
  logic [DATA_W-1:0] x_nxt;
  logic [DATA_W-1:0] wb_nxt;
  logic              we_nxt;
  logic              c_nxt;
  logic              z_nxt;
  logic              n_nxt;
  logic              v_nxt;
  logic [DATA_W-1:0] t;
  logic [DATA_W:0]   diff;
  logic [DATA_W-1:0] bh_inc;
  add_res_t          add_r;

  assign bh_inc = s1_base_high_r + {{(DATA_W-1){1'b0}}, 1'b1};

  always_comb begin
    a_nxt  = s1_acc_r;
    x_nxt  = s1_xreg_r;
    wb_nxt = '0;
    we_nxt = 1'b0;
    c_nxt  = s1_c_r;
    z_nxt  = s1_z_r;
    n_nxt  = s1_n_r;
    v_nxt  = s1_v_r;
    t      = '0;
    diff   = '0;
    add_r  = '0;
    case (kind_t'(s1_kind_r))
      KIND_ADC: begin
        add_r = adc_f(s1_acc_r, s1_mem_r, s1_c_r);
        a_nxt = add_r.res;
        c_nxt = add_r.c;
        v_nxt = add_r.v;
        z_nxt = (add_r.res == '0);
        n_nxt = add_r.res[DATA_W-1];
      end
      KIND_ALR: begin
        t     = s1_acc_r & s1_mem_r;
        c_nxt = t[0];
        a_nxt = {1'b0, t[DATA_W-1:1]};
        z_nxt = (t[DATA_W-1:1] == '0);
        n_nxt = 1'b0;
      end
      KIND_ANC: begin
        t     = s1_acc_r & s1_mem_r;
        a_nxt = t;
        z_nxt = (t == '0);
        n_nxt = t[DATA_W-1];
        c_nxt = t[DATA_W-1];
      end
      KIND_ARR: begin
        // rotate right through the old carry, then c and v from bits 6 and 5
        t     = s1_acc_r & s1_mem_r;
        a_nxt = {s1_c_r, t[DATA_W-1:1]};
        z_nxt = ({s1_c_r, t[DATA_W-1:1]} == '0);
        n_nxt = s1_c_r;
        c_nxt = t[DATA_W-1];
        v_nxt = t[DATA_W-1] ^ t[DATA_W-2];
      end
      KIND_AXS: begin
        t     = s1_acc_r & s1_xreg_r;
        diff  = {1'b0, t} - {1'b0, s1_mem_r};
        c_nxt = !diff[DATA_W];
        x_nxt = diff[DATA_W-1:0];
        z_nxt = (diff[DATA_W-1:0] == '0);
        n_nxt = diff[DATA_W-1];
      end
      KIND_DCP: begin
        t      = s1_mem_r - {{(DATA_W-1){1'b0}}, 1'b1};
        wb_nxt = t;
        we_nxt = 1'b1;
        diff   = {1'b0, s1_acc_r} - {1'b0, t};
        c_nxt  = !diff[DATA_W];
        z_nxt  = (diff[DATA_W-1:0] == '0);
        n_nxt  = diff[DATA_W-1];
      end
      KIND_ISB: begin
        t      = s1_mem_r + {{(DATA_W-1){1'b0}}, 1'b1};
        wb_nxt = t;
        we_nxt = 1'b1;
        add_r  = adc_f(s1_acc_r, ~t, s1_c_r);
        a_nxt  = add_r.res;
        c_nxt  = add_r.c;
        v_nxt  = add_r.v;
        z_nxt  = (add_r.res == '0);
        n_nxt  = add_r.res[DATA_W-1];
      end
      KIND_LAX: begin
        a_nxt = s1_mem_r;
        x_nxt = s1_mem_r;
        z_nxt = (s1_mem_r == '0);
        n_nxt = s1_mem_r[DATA_W-1];
      end
      KIND_RLA: begin
        t      = {s1_mem_r[DATA_W-2:0], s1_c_r};
        c_nxt  = s1_mem_r[DATA_W-1];
        wb_nxt = t;
        we_nxt = 1'b1;
        a_nxt  = s1_acc_r & t;
        z_nxt  = ((s1_acc_r & t) == '0);
        n_nxt  = s1_acc_r[DATA_W-1] & t[DATA_W-1];
      end
      KIND_RRA: begin
        // the add takes the carry shifted out by the rotate
        t      = {s1_c_r, s1_mem_r[DATA_W-1:1]};
        wb_nxt = t;
        we_nxt = 1'b1;
        add_r  = adc_f(s1_acc_r, t, s1_mem_r[0]);
        a_nxt  = add_r.res;
        c_nxt  = add_r.c;
        v_nxt  = add_r.v;
        z_nxt  = (add_r.res == '0);
        n_nxt  = add_r.res[DATA_W-1];
      end
      KIND_SAX: begin
        wb_nxt = s1_acc_r & s1_xreg_r;
        we_nxt = 1'b1;
      end
      KIND_SHX: begin
        wb_nxt = s1_xreg_r & bh_inc;
        we_nxt = 1'b1;
      end
      KIND_SHY: begin
        wb_nxt = s1_yreg_r & bh_inc;
        we_nxt = 1'b1;
      end
      KIND_SLO: begin
        t      = {s1_mem_r[DATA_W-2:0], 1'b0};
        c_nxt  = s1_mem_r[DATA_W-1];
        wb_nxt = t;
        we_nxt = 1'b1;
        a_nxt  = s1_acc_r | t;
        z_nxt  = ((s1_acc_r | t) == '0);
        n_nxt  = s1_acc_r[DATA_W-1] | t[DATA_W-1];
      end
      KIND_SRE: begin
        t      = {1'b0, s1_mem_r[DATA_W-1:1]};
        c_nxt  = s1_mem_r[0];
        wb_nxt = t;
        we_nxt = 1'b1;
        a_nxt  = s1_acc_r ^ t;
        z_nxt  = ((s1_acc_r ^ t) == '0);
        n_nxt  = s1_acc_r[DATA_W-1];
      end
      default: begin
        // unused code: everything passes through, no write
      end
    endcase
  end

  // result register
  logic              out_valid_r;
  logic              out_valid_nxt;
  logic [DATA_W-1:0] out_acc_r;
  logic [DATA_W-1:0] out_xreg_r;
  logic [DATA_W-1:0] out_wb_r;
  logic              out_we_r;
  logic              out_c_r;
  logic              out_z_r;
  logic              out_n_r;
  logic              out_v_r;

  assign out_valid_nxt = adv_out ? s1_valid_r : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_out && s1_valid_r) begin
      out_acc_r  <= a_nxt;
      out_xreg_r <= x_nxt;
      out_wb_r   <= wb_nxt;
      out_we_r   <= we_nxt;
      out_c_r    <= c_nxt;
      out_z_r    <= z_nxt;
      out_n_r    <= n_nxt;
      out_v_r    <= v_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_acc_out      = out_acc_r;
  assign out_xreg_out     = out_xreg_r;
  assign out_write_byte   = out_wb_r;
  assign out_write_enable = out_we_r;
  assign out_carry_out    = out_c_r;
  assign out_zero_out     = out_z_r;
  assign out_negative_out = out_n_r;
  assign out_overflow_out = out_v_r;

  // checks on the pipeline control
  `ASSERT_ALWAYS(a_stall_only_full, !in_stall || (s1_valid_r && out_valid_r && out_stall), "input stalled while pipeline has room")
  `ASSERT_NEXT(a_in_lands, in_valid && !in_stall, s1_valid_r, "accepted item lost at input stage")
  `ASSERT_NEXT(a_s1_moves, s1_valid_r && (!out_valid_r || !out_stall), out_valid_r, "item lost between stages")
  `ASSERT_ALWAYS(a_no_write_zero, !out_valid_r || out_we_r || (out_wb_r == '0), "write byte nonzero without write enable")

endmodule

// File: bench/mos6502_adc_and_illegal_op_alu_tb.sv
// self-checking testbench for the 6502 adc and undocumented-op alu slice
module mos6502_adc_and_illegal_op_alu_tb;
  import m6502alu_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // the one 4-bit code that the package leaves unnamed: a no-op
  localparam logic [KIND_W-1:0] KIND_UNUSED = 4'd15;

  // one operation as presented on the input channel
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [DATA_W-1:0] acc;
    logic [DATA_W-1:0] xr;
    logic [DATA_W-1:0] yr;
    logic [DATA_W-1:0] mem;
    logic [DATA_W-1:0] base_hi;
    logic              c;
    logic              z;
    logic              n;
    logic              v;
  } alu_op_t;

  // new registers, write-back byte and flags for one operation
  typedef struct packed {
    logic [DATA_W-1:0] acc;
    logic [DATA_W-1:0] xr;
    logic [DATA_W-1:0] wbyte;
    logic              wen;
    logic              c;
    logic              z;
    logic              n;
    logic              v;
  } alu_result_t;

  logic              clk;
  logic              rst_n            = 1'b0;
  logic              in_valid         = 1'b0;
  logic              in_stall;
  logic [KIND_W-1:0] in_kind          = '0;
  logic [DATA_W-1:0] in_acc_in        = '0;
  logic [DATA_W-1:0] in_xreg_in       = '0;
  logic [DATA_W-1:0] in_yreg_in       = '0;
  logic [DATA_W-1:0] in_mem_byte      = '0;
  logic [DATA_W-1:0] in_base_high     = '0;
  logic              in_carry_in      = 1'b0;
  logic              in_zero_in       = 1'b0;
  logic              in_negative_in   = 1'b0;
  logic              in_overflow_in   = 1'b0;
  logic              out_valid;
  logic              out_stall        = 1'b0;
  logic [DATA_W-1:0] out_acc_out;
  logic [DATA_W-1:0] out_xreg_out;
  logic [DATA_W-1:0] out_write_byte;
  logic              out_write_enable;
  logic              out_carry_out;
  logic              out_zero_out;
  logic              out_negative_out;
  logic              out_overflow_out;

  // expected results in acceptance order, oldest at the front
  alu_result_t pending_results[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int error_count   = 0;
  int accepted_ops  = 0;
  int checked_ops   = 0;
  int write_ops     = 0;
  int kind_hits[16];

  mos6502_adc_and_illegal_op_alu DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_kind          (in_kind),
    .in_acc_in        (in_acc_in),
    .in_xreg_in       (in_xreg_in),
    .in_yreg_in       (in_yreg_in),
    .in_mem_byte      (in_mem_byte),
    .in_base_high     (in_base_high),
    .in_carry_in      (in_carry_in),
    .in_zero_in       (in_zero_in),
    .in_negative_in   (in_negative_in),
    .in_overflow_in   (in_overflow_in),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_acc_out      (out_acc_out),
    .out_xreg_out     (out_xreg_out),
    .out_write_byte   (out_write_byte),
    .out_write_enable (out_write_enable),
    .out_carry_out    (out_carry_out),
    .out_zero_out     (out_zero_out),
    .out_negative_out (out_negative_out),
    .out_overflow_out (out_overflow_out)
  );

  // 4 ns clock, first rising edge at 2 ns
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // binary add with carry into the accumulator; c, v, z, n follow the sum
  function automatic alu_result_t add_into_acc(alu_result_t r, logic [DATA_W-1:0] m);
    logic [DATA_W:0]   sum;
    logic [DATA_W-1:0] res;
    sum   = {1'b0, r.acc} + {1'b0, m} + {{DATA_W{1'b0}}, r.c};
    res   = sum[DATA_W-1:0];
    r.c   = sum[DATA_W];
    r.v   = (m[7] ^ res[7]) & (res[7] ^ r.acc[7]);
    r.acc = res;
    r.z   = (res == '0);
    r.n   = res[7];
    return r;
  endfunction

  // what the alu should return for one operation
  function automatic alu_result_t compute_alu_result(alu_op_t op);
    alu_result_t       r;
    logic [DATA_W-1:0] t;
    logic [DATA_W-1:0] diff;
    // everything passes through unless the operation touches it
    r.acc   = op.acc;
    r.xr    = op.xr;
    r.wbyte = '0;
    r.wen   = 1'b0;
    r.c     = op.c;
    r.z     = op.z;
    r.n     = op.n;
    r.v     = op.v;
    case (op.kind)
      KIND_ADC: begin
        r = add_into_acc(r, op.mem);
      end
      KIND_ALR: begin
        t     = op.acc & op.mem;
        r.c   = t[0];
        r.acc = t >> 1;
        r.z   = (r.acc == '0);
        r.n   = r.acc[7];
      end
      KIND_ANC: begin
        r.acc = op.acc & op.mem;
        r.z   = (r.acc == '0);
        r.n   = r.acc[7];
        r.c   = r.acc[7];
      end
      KIND_ARR: begin
        // and, then rotate right through the incoming carry
        t     = op.acc & op.mem;
        r.acc = {op.c, t[7:1]};
        r.z   = (r.acc == '0);
        r.n   = r.acc[7];
        r.c   = r.acc[6];
        r.v   = r.acc[6] ^ r.acc[5];
      end
      KIND_AXS: begin
        t    = op.acc & op.xr;
        r.c  = (t >= op.mem);
        r.xr = t - op.mem;
        r.z  = (r.xr == '0);
        r.n  = r.xr[7];
      end
      KIND_DCP: begin
        t       = op.mem - 8'd1;
        diff    = op.acc - t;
        r.wbyte = t;
        r.wen   = 1'b1;
        r.z     = (diff == '0);
        r.n     = diff[7];
        r.c     = (op.acc >= t);
      end
      KIND_ISB: begin
        // increment memory, then subtract it with borrow
        t       = op.mem + 8'd1;
        r.wbyte = t;
        r.wen   = 1'b1;
        r = add_into_acc(r, ~t);
      end
      KIND_LAX: begin
        r.acc = op.mem;
        r.xr  = op.mem;
        r.z   = (op.mem == '0);
        r.n   = op.mem[7];
      end
      KIND_RLA: begin
        t       = {op.mem[6:0], op.c};
        r.c     = op.mem[7];
        r.wbyte = t;
        r.wen   = 1'b1;
        r.acc   = op.acc & t;
        r.z     = (r.acc == '0);
        r.n     = r.acc[7];
      end
      KIND_RRA: begin
        // the carry shifted out of memory feeds the add
        t       = {op.c, op.mem[7:1]};
        r.c     = op.mem[0];
        r.wbyte = t;
        r.wen   = 1'b1;
        r = add_into_acc(r, t);
      end
      KIND_SAX: begin
        r.wbyte = op.acc & op.xr;
        r.wen   = 1'b1;
      end
      KIND_SHX: begin
        r.wbyte = op.xr & (op.base_hi + 8'd1);
        r.wen   = 1'b1;
      end
      KIND_SHY: begin
        r.wbyte = op.yr & (op.base_hi + 8'd1);
        r.wen   = 1'b1;
      end
      KIND_SLO: begin
        t       = {op.mem[6:0], 1'b0};
        r.c     = op.mem[7];
        r.wbyte = t;
        r.wen   = 1'b1;
        r.acc   = op.acc | t;
        r.z     = (r.acc == '0);
        r.n     = r.acc[7];
      end
      KIND_SRE: begin
        t       = {1'b0, op.mem[7:1]};
        r.c     = op.mem[0];
        r.wbyte = t;
        r.wen   = 1'b1;
        r.acc   = op.acc ^ t;
        r.z     = (r.acc == '0);
        r.n     = r.acc[7];
      end
      default: begin
        // unused code: no-op
      end
    endcase
    return r;
  endfunction

  function automatic alu_op_t make_op(logic [KIND_W-1:0] kind, logic [DATA_W-1:0] acc,
                                      logic [DATA_W-1:0] xr, logic [DATA_W-1:0] yr,
                                      logic [DATA_W-1:0] mem, logic [DATA_W-1:0] base_hi,
                                      logic c, logic z, logic n, logic v);
    alu_op_t op;
    op.kind    = kind;
    op.acc     = acc;
    op.xr      = xr;
    op.yr      = yr;
    op.mem     = mem;
    op.base_hi = base_hi;
    op.c       = c;
    op.z       = z;
    op.n       = n;
    op.v       = v;
    return op;
  endfunction

  // byte values lean toward the edges where carries and signs flip
  function automatic logic [DATA_W-1:0] pick_byte();
    case ($urandom_range(9))
      0:       return 8'h00;
      1:       return 8'hff;
      2:       return 8'h80;
      3:       return 8'h7f;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // present one item, with random gaps ahead of it, and hold it until accepted
  task automatic send_op(alu_op_t op);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_kind        <= op.kind;
    in_acc_in      <= op.acc;
    in_xreg_in     <= op.xr;
    in_yreg_in     <= op.yr;
    in_mem_byte    <= op.mem;
    in_base_high   <= op.base_hi;
    in_carry_in    <= op.c;
    in_zero_in     <= op.z;
    in_negative_in <= op.n;
    in_overflow_in <= op.v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // every kind code once, fields at their extremes, flags all set or all clear
  task automatic test_kind_sweep();
    int       k;
    logic     hi;
    for (k = KIND_ADC; k <= KIND_UNUSED; k++) begin
      hi = ~k[0];
      send_op(make_op(KIND_W'(k), {8{hi}}, {8{~hi}}, {8{hi}}, {8{~hi}}, {8{hi}},
                      hi, hi, hi, hi));
    end
  endtask

  // carry, borrow, overflow, arr flag rules and the base-address wrap
  task automatic test_corner_cases();
    // signed overflow, then carry out with zero result
    send_op(make_op(KIND_ADC, 8'h7f, 8'h00, 8'h00, 8'h01, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0));
    send_op(make_op(KIND_ADC, 8'hff, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 1'b0, 1'b1, 1'b1));
    // memory increment wraps to zero, then a plain borrow
    send_op(make_op(KIND_ISB, 8'h80, 8'h00, 8'h00, 8'hff, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0));
    send_op(make_op(KIND_ISB, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1, 1'b0, 1'b1));
    // arr: carry from bit 6, overflow from bit 6 xor bit 5
    send_op(make_op(KIND_ARR, 8'hff, 8'h00, 8'h00, 8'hff, 8'h00, 1'b1, 1'b0, 1'b0, 1'b1));
    send_op(make_op(KIND_ARR, 8'hff, 8'h00, 8'h00, 8'h40, 8'h00, 1'b0, 1'b1, 1'b1, 1'b0));
    send_op(make_op(KIND_ARR, 8'hff, 8'h00, 8'h00, 8'h80, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0));
    // base high byte plus one wraps to zero, and a mid value
    send_op(make_op(KIND_SHX, 8'h00, 8'hff, 8'h00, 8'h00, 8'hff, 1'b0, 1'b0, 1'b0, 1'b0));
    send_op(make_op(KIND_SHY, 8'h00, 8'h00, 8'ha5, 8'h00, 8'h7f, 1'b1, 1'b1, 1'b1, 1'b1));
  endtask

  task automatic test_random_ops(int count);
    int i;
    for (i = 0; i < count; i++) begin
      send_op(make_op(KIND_W'($urandom_range(KIND_UNUSED)), pick_byte(), pick_byte(),
                      pick_byte(), pick_byte(), pick_byte(),
                      1'($urandom_range(1)), 1'($urandom_range(1)),
                      1'($urandom_range(1)), 1'($urandom_range(1))));
    end
  endtask

  // receiver back-pressure, at the rate of the current phase
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // scoreboard: predict on input acceptance, compare on output acceptance
  always @(posedge clk) begin
    alu_result_t got;
    alu_result_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        pending_results.push_back(compute_alu_result(make_op(
          in_kind, in_acc_in, in_xreg_in, in_yreg_in, in_mem_byte, in_base_high,
          in_carry_in, in_zero_in, in_negative_in, in_overflow_in)));
        kind_hits[in_kind]++;
        accepted_ops++;
      end
      if (out_valid && !out_stall) begin
        got.acc   = out_acc_out;
        got.xr    = out_xreg_out;
        got.wbyte = out_write_byte;
        got.wen   = out_write_enable;
        got.c     = out_carry_out;
        got.z     = out_zero_out;
        got.n     = out_negative_out;
        got.v     = out_overflow_out;
        checked_ops++;
        if (pending_results.size() == 0) begin
          if (error_count < 10)
            $display("[%0t] result with nothing pending: a=%02h x=%02h wb=%02h", $realtime,
                     got.acc, got.xr, got.wbyte);
          error_count++;
        end else begin
          want = pending_results.pop_front();
          if (want.wen) write_ops++;
          if (got.acc !== want.acc || got.xr !== want.xr || got.wbyte !== want.wbyte ||
              got.wen !== want.wen || got.c !== want.c || got.z !== want.z ||
              got.n !== want.n || got.v !== want.v) begin
            if (error_count < 10) begin
              $display("[%0t] mismatch on result %0d", $realtime, checked_ops);
              $display("  expected a=%02h x=%02h wb=%02h we=%b c=%b z=%b n=%b v=%b",
                       want.acc, want.xr, want.wbyte, want.wen, want.c, want.z, want.n,
                       want.v);
              $display("  actual   a=%02h x=%02h wb=%02h we=%b c=%b z=%b n=%b v=%b",
                       got.acc, got.xr, got.wbyte, got.wen, got.c, got.z, got.n, got.v);
            end
            error_count++;
          end
        end
      end
    end
  end

  // main sequence
  initial begin
    int drain_cycles;
    int kinds_seen;
    drain_cycles = 0;
    kinds_seen   = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // phase one: sender gaps are light, receiver stalls heavily
    send_idle_pct = 26;
    recv_idle_pct = 85;
    test_kind_sweep();
    test_corner_cases();
    test_random_ops(225);

    // phase two: the opposite balance
    send_idle_pct = 85;
    recv_idle_pct = 26;
    test_random_ops(225);

    // phase three: full rate both ways
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_ops(225);
    in_valid <= 1'b0;

    // let the pipeline empty, then wait on for any stray result
    while (pending_results.size() != 0 && drain_cycles < 5000) begin
      @(posedge clk);
      drain_cycles++;
    end
    repeat (8) @(posedge clk);
    if (pending_results.size() != 0) begin
      $display("%0d expected results never arrived", pending_results.size());
      error_count++;
    end

    foreach (kind_hits[k]) if (kind_hits[k] != 0) kinds_seen++;
    $display("items sent %0d, results checked %0d (%0d with memory write), kind codes hit %0d",
             accepted_ops, checked_ops, write_ops, kinds_seen);
    $display("flow control: heavy stall, heavy gaps, then full rate; failures %0d",
             error_count);
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // watchdog: far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("watchdog expired with %0d results pending", pending_results.size());
    $display("Regression FAIL");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl
rtl/m6502alu_pkg.sv
rtl/mos6502_adc_and_illegal_op_alu.sv
bench/mos6502_adc_and_illegal_op_alu_tb.sv
